@@ rtl/mbr_ptp_pkg.sv @@
// ---------------------------------------------------------------------------
// mbr_ptp_pkg
// Shared constants, types and control records of the MBR partition table
// parser.
// ---------------------------------------------------------------------------
package mbr_ptp_pkg;

  localparam int unsigned EntryCount = 4;
  localparam int unsigned SlotW      = $clog2(EntryCount);
  localparam int unsigned CursorW    = SlotW + 1;

  localparam logic [8:0] TableOffset = 9'd446;
  localparam logic [8:0] SigLowPos   = 9'd510;
  localparam logic [8:0] SigHighPos  = 9'd511;

  localparam logic [7:0] SigLowValue  = 8'h55;
  localparam logic [7:0] SigHighValue = 8'hAA;

  localparam logic [3:0] OffType    = 4'd4;
  localparam logic [3:0] OffStart0  = 4'd8;
  localparam logic [3:0] OffStart1  = 4'd9;
  localparam logic [3:0] OffStart2  = 4'd10;
  localparam logic [3:0] OffStart3  = 4'd11;
  localparam logic [3:0] OffCount0  = 4'd12;
  localparam logic [3:0] OffCount1  = 4'd13;
  localparam logic [3:0] OffCount2  = 4'd14;
  localparam logic [3:0] OffCount3  = 4'd15;

  localparam int unsigned PaddrW    = 3;
  localparam logic        RegBlockSizeShift = 1'b0;

  typedef struct packed {
    logic [7:0]  ptype;
    logic [31:0] start;
    logic [31:0] count;
  } slot_t;

  typedef enum logic [1:0] {
    ST_RECV = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  typedef struct packed {
    logic capture;
    logic start_emit;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic end_byte;
    logic sel_last;
  } dp_status_t;

endpackage

@@ rtl/mbr_ptp_if.sv @@
// ---------------------------------------------------------------------------
// mbr_ptp_in_if / mbr_ptp_out_if
// Valid/ready channels carrying sector bytes in and partition results out.
// ---------------------------------------------------------------------------
interface mbr_ptp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       sector_start;

  modport source (output valid, output data_byte, output sector_start, input ready);
  modport sink   (input valid, input data_byte, input sector_start, output ready);
endinterface

interface mbr_ptp_out_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic        signature_ok;
  logic [1:0]  entry_index;
  logic [7:0]  partition_type;
  logic [31:0] first_block;
  logic [31:0] block_count;
  logic        last;

  modport source (output valid, output entry_valid, output signature_ok,
                  output entry_index, output partition_type, output first_block,
                  output block_count, output last, input ready);
  modport sink   (input valid, input entry_valid, input signature_ok,
                  input entry_index, input partition_type, input first_block,
                  input block_count, input last, output ready);
endinterface

@@ rtl/mbr_ptp_datapath.sv @@
// ---------------------------------------------------------------------------
// mbr_ptp_datapath
// Byte position counter, partition entry store, signature check, result
// selection and output payload register.
// ---------------------------------------------------------------------------
module mbr_ptp_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mbr_ptp_pkg::dp_cmd_t  cmd_i,
  output mbr_ptp_pkg::dp_status_t status_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  sector_start_i,
  input  logic [1:0]            shift_i,
  output logic                  entry_valid_o,
  output logic                  signature_ok_o,
  output logic [1:0]            entry_index_o,
  output logic [7:0]            partition_type_o,
  output logic [31:0]           first_block_o,
  output logic [31:0]           block_count_o,
  output logic                  last_o
);

  logic [8:0] pos_q, pos_d, pos;
  logic [7:0] sig_low_q, sig_low_d;
  logic       sig_ok_q, sig_ok_d;
  logic [mbr_ptp_pkg::CursorW-1:0] cursor_q, cursor_d;

  mbr_ptp_pkg::slot_t store_q [mbr_ptp_pkg::EntryCount];

  logic [8:0] rel;
  logic [mbr_ptp_pkg::SlotW-1:0] wr_slot;
  logic [3:0] wr_off;
  logic       in_table;

  logic [mbr_ptp_pkg::EntryCount-1:0] used;
  logic       sel_found;
  logic       sel_more;
  logic [mbr_ptp_pkg::SlotW-1:0] sel_idx;
  mbr_ptp_pkg::slot_t sel_slot;

  assign pos      = sector_start_i ? 9'd0 : pos_q;
  assign rel      = pos - mbr_ptp_pkg::TableOffset;
  assign wr_slot  = rel[mbr_ptp_pkg::SlotW+3:4];
  assign wr_off   = rel[3:0];
  assign in_table = (pos >= mbr_ptp_pkg::TableOffset) && (pos < mbr_ptp_pkg::SigLowPos);

  assign status_o.end_byte = (pos == mbr_ptp_pkg::SigHighPos);

  always_comb begin
    sel_found = 1'b0;
    sel_more  = 1'b0;
    sel_idx   = '0;
    for (int i = 0; i < mbr_ptp_pkg::EntryCount; i++) begin
      used[i] = sig_ok_q && (store_q[i].ptype != 8'd0);
    end
    for (int i = mbr_ptp_pkg::EntryCount - 1; i >= 0; i--) begin
      if (used[i] && (mbr_ptp_pkg::CursorW'(i) >= cursor_q)) begin
        if (sel_found) begin
          sel_more = 1'b1;
        end
        sel_found = 1'b1;
        sel_idx   = mbr_ptp_pkg::SlotW'(i);
      end
    end
    sel_slot = store_q[sel_idx];
  end

  assign status_o.sel_last = !sel_more;

  always_comb begin
    pos_d     = pos_q;
    sig_low_d = sig_low_q;
    sig_ok_d  = sig_ok_q;
    cursor_d  = cursor_q;
    if (cmd_i.capture) begin
      pos_d = pos + 9'd1;
      if (pos == mbr_ptp_pkg::SigLowPos) begin
        sig_low_d = data_byte_i;
      end
    end
    if (cmd_i.start_emit) begin
      sig_ok_d = (sig_low_q == mbr_ptp_pkg::SigLowValue) &&
                 (data_byte_i == mbr_ptp_pkg::SigHighValue);
      cursor_d = '0;
    end
    if (cmd_i.load_result) begin
      cursor_d = {1'b0, sel_idx} + mbr_ptp_pkg::CursorW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      sig_low_q <= '0;
      sig_ok_q  <= 1'b0;
      cursor_q  <= '0;
    end else begin
      pos_q     <= pos_d;
      sig_low_q <= sig_low_d;
      sig_ok_q  <= sig_ok_d;
      cursor_q  <= cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && in_table) begin
      case (wr_off)
        mbr_ptp_pkg::OffType:   store_q[wr_slot].ptype        <= data_byte_i;
        mbr_ptp_pkg::OffStart0: store_q[wr_slot].start[7:0]   <= data_byte_i;
        mbr_ptp_pkg::OffStart1: store_q[wr_slot].start[15:8]  <= data_byte_i;
        mbr_ptp_pkg::OffStart2: store_q[wr_slot].start[23:16] <= data_byte_i;
        mbr_ptp_pkg::OffStart3: store_q[wr_slot].start[31:24] <= data_byte_i;
        mbr_ptp_pkg::OffCount0: store_q[wr_slot].count[7:0]   <= data_byte_i;
        mbr_ptp_pkg::OffCount1: store_q[wr_slot].count[15:8]  <= data_byte_i;
        mbr_ptp_pkg::OffCount2: store_q[wr_slot].count[23:16] <= data_byte_i;
        mbr_ptp_pkg::OffCount3: store_q[wr_slot].count[31:24] <= data_byte_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      entry_valid_o  <= sel_found;
      signature_ok_o <= sig_ok_q;
      last_o         <= !sel_more;
      if (sel_found) begin
        entry_index_o    <= sel_idx;
        partition_type_o <= sel_slot.ptype;
        first_block_o    <= sel_slot.start >> shift_i;
        block_count_o    <= sel_slot.count >> shift_i;
      end else begin
        entry_index_o    <= '0;
        partition_type_o <= '0;
        first_block_o    <= '0;
        block_count_o    <= '0;
      end
    end
  end

endmodule

@@ rtl/mbr_ptp_ctrl.sv @@
// ---------------------------------------------------------------------------
// mbr_ptp_ctrl
// Receive/emit sequencer and output register valid flag.
// ---------------------------------------------------------------------------
module mbr_ptp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output mbr_ptp_pkg::dp_cmd_t    cmd_o,
  input  mbr_ptp_pkg::dp_status_t status_i
);

  mbr_ptp_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic load;

  assign in_ready_o  = (state_q == mbr_ptp_pkg::ST_RECV);
  assign accept      = in_valid_i && in_ready_o;
  assign load        = (state_q == mbr_ptp_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture     = accept;
  assign cmd_o.start_emit  = accept && status_i.end_byte;
  assign cmd_o.load_result = load;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
    case (state_q)
      mbr_ptp_pkg::ST_RECV: begin
        if (cmd_o.start_emit) begin
          state_d = mbr_ptp_pkg::ST_EMIT;
        end
      end
      mbr_ptp_pkg::ST_EMIT: begin
        if (load && status_i.sel_last) begin
          state_d = mbr_ptp_pkg::ST_RECV;
        end
      end
      default: state_d = mbr_ptp_pkg::ST_RECV;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbr_ptp_pkg::ST_RECV;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_emit_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_emit |=> (state_q == mbr_ptp_pkg::ST_EMIT))
    else $error("emit not entered after final sector byte");

  a_recv_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && status_i.sel_last) |=> (state_q == mbr_ptp_pkg::ST_RECV) && out_valid_q)
    else $error("receive not resumed after final result");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(load))
    else $error("output valid raised without a result load");

endmodule

@@ rtl/mbr_partition_table_parser.sv @@
// ---------------------------------------------------------------------------
// mbr_partition_table_parser
// Parses the partition table of a 512-byte first sector and reports each
// used entry, or one status result, with start and count scaled by the
// configured block size shift.
// ---------------------------------------------------------------------------
// Bytes 0..511 are taken at one per cycle. After byte 511 input holds while
// 1 to 4 results are loaded, one per cycle as the output register frees up.
// Taking byte 511 moves the sequencer to its emit state, which then loads
// the first result into the output register and raises its valid flag.
// Reset clears the byte position, signature byte and shift register; the
// entry store has no reset and is rewritten by every sector.
module mbr_partition_table_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbr_ptp_in_if.sink  in_i,
  mbr_ptp_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [mbr_ptp_pkg::PaddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] shift_q, shift_d;
  logic       reg_sel;
  mbr_ptp_pkg::dp_cmd_t    cmd;
  mbr_ptp_pkg::dp_status_t status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[mbr_ptp_pkg::PaddrW-1] == mbr_ptp_pkg::RegBlockSizeShift);
  assign prdata  = reg_sel ? {30'd0, shift_q} : 32'd0;

  always_comb begin
    shift_d = shift_q;
    if (psel && penable && pwrite && reg_sel) begin
      shift_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else begin
      shift_q <= shift_d;
    end
  end

  mbr_ptp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  mbr_ptp_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .data_byte_i      (in_i.data_byte),
    .sector_start_i   (in_i.sector_start),
    .shift_i          (shift_q),
    .entry_valid_o    (out_o.entry_valid),
    .signature_ok_o   (out_o.signature_ok),
    .entry_index_o    (out_o.entry_index),
    .partition_type_o (out_o.partition_type),
    .first_block_o    (out_o.first_block),
    .block_count_o    (out_o.block_count),
    .last_o           (out_o.last)
  );

endmodule

@@ tb/sv/mbr_ptp_result_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbr_ptp_result_checker
// Follows every sector byte taken by the parser, keeps its own copy of the
// byte position, the captured table entries and the block size shift, and
// works out the partition results due after byte 511. Each result that
// leaves the output channel is compared field by field with the oldest one
// due. Register reads are checked against the shift last written.
// ---------------------------------------------------------------------------
module mbr_ptp_result_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  mbr_ptp_in_if             in_i,
  mbr_ptp_out_if            out_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [mbr_ptp_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int unsigned       mismatch_count_o,
  output int unsigned       results_due_o
);

  localparam logic [mbr_ptp_pkg::PaddrW-1:0] ShiftAddr =
    mbr_ptp_pkg::PaddrW'(4 * mbr_ptp_pkg::RegBlockSizeShift);
  localparam int unsigned       PrintCap  = 30;

  typedef struct packed {
    logic        entry_valid;
    logic        signature_ok;
    logic [1:0]  entry_index;
    logic [7:0]  partition_type;
    logic [31:0] first_block;
    logic [31:0] block_count;
    logic        last;
  } result_t;

  logic [8:0]  byte_pos;
  mbr_ptp_pkg::slot_t slots [mbr_ptp_pkg::EntryCount];
  logic [7:0]  sig_low;
  logic [1:0]  block_shift;
  result_t     due_results [$];
  int unsigned n_due = 0;
  int unsigned fails = 0;

  assign mismatch_count_o = fails;
  assign results_due_o    = n_due;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fails < PrintCap) begin
      $display("%0t ns: %s got %0h, want %0h", $time, what, got, want);
    end
    fails++;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      report("result with nothing due, entry_index", 32'(got.entry_index), '0);
      return;
    end
    want = due_results.pop_front();
    n_due = due_results.size();
    if (got.entry_valid !== want.entry_valid) begin
      report("entry_valid", 32'(got.entry_valid), 32'(want.entry_valid));
    end
    if (got.signature_ok !== want.signature_ok) begin
      report("signature_ok", 32'(got.signature_ok), 32'(want.signature_ok));
    end
    if (got.entry_index !== want.entry_index) begin
      report("entry_index", 32'(got.entry_index), 32'(want.entry_index));
    end
    if (got.partition_type !== want.partition_type) begin
      report("partition_type", 32'(got.partition_type), 32'(want.partition_type));
    end
    if (got.first_block !== want.first_block) begin
      report("first_block", got.first_block, want.first_block);
    end
    if (got.block_count !== want.block_count) begin
      report("block_count", got.block_count, want.block_count);
    end
    if (got.last !== want.last) begin
      report("last", 32'(got.last), 32'(want.last));
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic restart);
    logic [8:0]  pos;
    logic [8:0]  rel;
    int unsigned slot;
    logic [3:0]  off;
    int          lane;
    logic        sig;
    int          last_used;
    int          i;
    result_t     r;
    pos = restart ? 9'd0 : byte_pos;
    if (pos >= mbr_ptp_pkg::TableOffset && pos < mbr_ptp_pkg::SigLowPos) begin
      rel  = pos - mbr_ptp_pkg::TableOffset;
      slot = {30'd0, rel[5:4]};
      off  = rel[3:0];
      if (off == mbr_ptp_pkg::OffType) begin
        slots[slot].ptype = b;
      end else if (off >= mbr_ptp_pkg::OffStart0 && off <= mbr_ptp_pkg::OffStart3) begin
        lane = int'(off) - int'(mbr_ptp_pkg::OffStart0);
        slots[slot].start[8*lane +: 8] = b;
      end else if (off >= mbr_ptp_pkg::OffCount0) begin
        lane = int'(off) - int'(mbr_ptp_pkg::OffCount0);
        slots[slot].count[8*lane +: 8] = b;
      end
    end else if (pos == mbr_ptp_pkg::SigLowPos) begin
      sig_low = b;
    end else if (pos == mbr_ptp_pkg::SigHighPos) begin
      sig = (sig_low == mbr_ptp_pkg::SigLowValue) && (b == mbr_ptp_pkg::SigHighValue);
      last_used = -1;
      if (sig) begin
        for (i = 0; i < mbr_ptp_pkg::EntryCount; i++) begin
          if (slots[i].ptype != 8'h00) last_used = i;
        end
      end
      if (last_used < 0) begin
        r = '0;
        r.signature_ok = sig;
        r.last = 1'b1;
        due_results.push_back(r);
      end else begin
        for (i = 0; i < mbr_ptp_pkg::EntryCount; i++) begin
          if (slots[i].ptype != 8'h00) begin
            r.entry_valid    = 1'b1;
            r.signature_ok   = 1'b1;
            r.entry_index    = 2'(i);
            r.partition_type = slots[i].ptype;
            r.first_block    = slots[i].start >> block_shift;
            r.block_count    = slots[i].count >> block_shift;
            r.last           = (i == last_used);
            due_results.push_back(r);
          end
        end
      end
      n_due = due_results.size();
    end
    byte_pos = pos + 9'd1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos    = '0;
      sig_low     = '0;
      block_shift = '0;
      foreach (slots[i]) slots[i] = '0;
      due_results.delete();
      n_due = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        check_result({out_i.entry_valid, out_i.signature_ok, out_i.entry_index,
                      out_i.partition_type, out_i.first_block, out_i.block_count,
                      out_i.last});
      end
      if (in_i.valid && in_i.ready) begin
        parse_byte(in_i.data_byte, in_i.sector_start);
      end
      if (psel && penable && pready && paddr == ShiftAddr) begin
        if (pwrite) begin
          block_shift = pwdata[1:0];
        end else if (prdata !== {30'd0, block_shift}) begin
          report("block_size_shift read", prdata, {30'd0, block_shift});
        end
      end
    end
  end

endmodule

@@ tb/sv/mbr_partition_table_parser_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbr_partition_table_parser_test
// Feeds whole and broken first sectors into the partition table parser:
// a directed set covering status results, extreme entry values, wrap into
// back-to-back sectors and restarts part way through, then random sectors
// under three idling patterns and three shift settings, with one long output
// hold-off. A separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module mbr_partition_table_parser_test;

  localparam int unsigned SectorBytes = 512;
  localparam int unsigned EntryBytes  = 16;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned HoldCycles  = 700;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseSectors = 12;
  localparam int unsigned TableBase   = int'(mbr_ptp_pkg::TableOffset);
  localparam int unsigned TypeOff     = int'(mbr_ptp_pkg::OffType);
  localparam int unsigned StartOff    = int'(mbr_ptp_pkg::OffStart0);
  localparam int unsigned CountOff    = int'(mbr_ptp_pkg::OffCount0);
  localparam int unsigned SigLowIdx   = int'(mbr_ptp_pkg::SigLowPos);
  localparam int unsigned SigHighIdx  = int'(mbr_ptp_pkg::SigHighPos);
  localparam logic [mbr_ptp_pkg::PaddrW-1:0] ShiftAddr =
    mbr_ptp_pkg::PaddrW'(4 * mbr_ptp_pkg::RegBlockSizeShift);

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [mbr_ptp_pkg::PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int unsigned       mismatch_count;
  int unsigned       results_due;
  int unsigned       tx_idle_pct;
  int unsigned       rx_idle_pct;
  int unsigned       hold_asked;
  int unsigned       quiet_cycles = 0;
  logic [7:0]        sector [SectorBytes];

  mbr_ptp_in_if  in_ch ();
  mbr_ptp_out_if out_ch ();

  mbr_partition_table_parser dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mbr_ptp_result_checker result_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_ch),
    .out_i            (out_ch),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .results_due_o    (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_taken;
    hold_left  = 0;
    hold_taken = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left  = HoldCycles;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IdleLimit) begin
      $display("mbr_partition_table_parser: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer_byte(input logic [7:0] b, input logic restart);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.sector_start <= restart;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // stray_at >= n_bytes means no mark after the first byte
  task automatic send_sector(input int unsigned n_bytes, input logic marked,
                             input int unsigned stray_at);
    int unsigned k;
    for (k = 0; k < n_bytes; k++) begin
      offer_byte(sector[k], (marked && k == 0) || k == stray_at);
    end
  endtask

  task automatic fill_sector();
    int unsigned k;
    for (k = 0; k < SectorBytes; k++) sector[k] = 8'($urandom_range(255));
    for (k = 0; k < mbr_ptp_pkg::EntryCount; k++) begin
      sector[TableBase + EntryBytes * k + TypeOff] = 8'h00;
    end
    sector[SigLowIdx]  = mbr_ptp_pkg::SigLowValue;
    sector[SigHighIdx] = mbr_ptp_pkg::SigHighValue;
  endtask

  task automatic put_entry(input int unsigned slot, input logic [7:0] ptype,
                           input logic [31:0] first, input logic [31:0] count);
    int unsigned base;
    int unsigned b;
    base = TableBase + EntryBytes * slot;
    sector[base + TypeOff] = ptype;
    for (b = 0; b < 4; b++) begin
      sector[base + StartOff + b] = first[8*b +: 8];
      sector[base + CountOff + b] = count[8*b +: 8];
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // drop valid, wait for every result, then let the parser go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (results_due != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_block_shift(input logic [1:0] shift);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ShiftAddr;
    pwdata  <= {30'd0, shift};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_sectors(input int unsigned n_sectors);
    int unsigned n;
    int unsigned s;
    logic        whole;
    whole = 1'b0;
    for (n = 0; n < n_sectors; n++) begin
      fill_sector();
      for (s = 0; s < mbr_ptp_pkg::EntryCount; s++) begin
        put_entry(s, ($urandom_range(9) < 3) ? 8'h00 : 8'($urandom_range(255, 1)),
                  pick_word(), pick_word());
      end
      if ($urandom_range(9) == 0) sector[SigLowIdx] = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) sector[SigHighIdx] = 8'($urandom_range(255));
      case ($urandom_range(9))
        0: begin
          send_sector($urandom_range(SectorBytes - 1, 1), 1'b1, SectorBytes);
          whole = 1'b0;
        end
        1: begin
          send_sector(SectorBytes, 1'b1, $urandom_range(SectorBytes - 1, 1));
          whole = 1'b0;
        end
        default: begin
          send_sector(SectorBytes, !whole || $urandom_range(3) != 0, SectorBytes);
          whole = 1'b1;
        end
      endcase
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= 8'h00;
    in_ch.sector_start <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    tx_idle_pct        <= 25;
    rx_idle_pct        <= 72;
    hold_asked         <= 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // good signature but no used entry
    fill_sector();
    put_entry(0, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_entry(3, 8'h00, 32'h0000_0001, 32'h8000_0000);
    send_sector(SectorBytes, 1'b1, SectorBytes);
    // last slot only, carried on from the wrap without a mark
    fill_sector();
    put_entry(3, 8'h0C, $urandom(), $urandom());
    send_sector(SectorBytes, 1'b0, SectorBytes);
    // break off inside the table, restart mid sector, then a clean pass
    fill_sector();
    put_entry(0, 8'h06, $urandom(), $urandom());
    put_entry(2, 8'h0B, $urandom(), $urandom());
    send_sector(470, 1'b1, SectorBytes);
    fill_sector();
    put_entry(1, 8'h05, $urandom(), $urandom());
    send_sector(SectorBytes, 1'b1, 300);
    send_sector(SectorBytes, 1'b1, SectorBytes);
    // extremes under the reset shift, the largest shift and a middle one
    fill_sector();
    put_entry(0, 8'h01, 32'h0000_0000, 32'hFFFF_FFFF);
    put_entry(1, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
    put_entry(2, 8'h83, 32'h0000_0800, 32'h1234_5678);
    put_entry(3, 8'h07, 32'h8000_0001, 32'hA5A5_A5A5);
    send_sector(SectorBytes, 1'b1, SectorBytes);
    settle();
    set_block_shift(2'd3);
    send_sector(SectorBytes, 1'b0, SectorBytes);
    settle();
    set_block_shift(2'd1);
    send_sector(SectorBytes, 1'b1, SectorBytes);
    // bad high signature byte, then bad low signature byte
    sector[SigHighIdx] = mbr_ptp_pkg::SigLowValue;
    send_sector(SectorBytes, 1'b1, SectorBytes);
    sector[SigLowIdx]  = mbr_ptp_pkg::SigHighValue;
    sector[SigHighIdx] = mbr_ptp_pkg::SigHighValue;
    send_sector(SectorBytes, 1'b0, SectorBytes);

    settle();
    set_block_shift(2'd2);
    random_sectors(PhaseSectors);

    settle();
    set_block_shift(2'd0);
    tx_idle_pct <= 72;
    rx_idle_pct <= 25;
    random_sectors(PhaseSectors);

    settle();
    set_block_shift(2'd3);
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    // hold the output while a whole sector streams in
    sector[SigLowIdx]  = mbr_ptp_pkg::SigLowValue;
    sector[SigHighIdx] = mbr_ptp_pkg::SigHighValue;
    hold_asked <= hold_asked + 1;
    send_sector(SectorBytes, 1'b1, SectorBytes);
    random_sectors(PhaseSectors);

    settle();
    if (mismatch_count == 0 && results_due == 0) begin
      $display("mbr_partition_table_parser: match");
    end else begin
      $display("mbr_partition_table_parser: mismatch");
    end
    $finish;
  end

endmodule

@@ mbr_partition_table_parser.f @@
rtl/mbr_ptp_pkg.sv
rtl/mbr_ptp_if.sv
rtl/mbr_ptp_datapath.sv
rtl/mbr_ptp_ctrl.sv
rtl/mbr_partition_table_parser.sv
tb/sv/mbr_ptp_result_checker.sv
tb/sv/mbr_partition_table_parser_test.sv
